// ===== hw/rtl/jca_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the joint angle pipeline.
package jca_pkg;

    localparam int COORD_BITS_DEF      = 12;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STEPS_DEF    = 16;

    // Coordinates are scaled up by this shift before the first rotation.
    localparam int PRE_SHIFT = 24;
    // Fraction bits of the angle accumulator.
    localparam int ACC_FRAC  = 20;
    localparam int TABLE_LEN = 24;
    // The accumulator stays below 100 degrees at 20 fraction bits.
    localparam int Z_W       = 28;
    // Working width for the final angle sums, wide enough for 12 fraction bits.
    localparam int ANG_W     = 24;
    localparam int OUT_W     = 18;
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_EQ  = 2'd0,
        KIND_NEG = 2'd1,
        KIND_POS = 2'd2
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t kind1;
        seg_kind_t kind2;
    } side_t;

    // atan(2^-i) in degrees, scaled by 2^ACC_FRAC.
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = Z_W'(47185920);
            5'd1:    v = Z_W'(27855475);
            5'd2:    v = Z_W'(14718068);
            5'd3:    v = Z_W'(7471121);
            5'd4:    v = Z_W'(3750058);
            5'd5:    v = Z_W'(1876857);
            5'd6:    v = Z_W'(938658);
            5'd7:    v = Z_W'(469357);
            5'd8:    v = Z_W'(234682);
            5'd9:    v = Z_W'(117342);
            5'd10:   v = Z_W'(58671);
            5'd11:   v = Z_W'(29335);
            5'd12:   v = Z_W'(14668);
            5'd13:   v = Z_W'(7334);
            5'd14:   v = Z_W'(3667);
            5'd15:   v = Z_W'(1833);
            5'd16:   v = Z_W'(917);
            5'd17:   v = Z_W'(458);
            5'd18:   v = Z_W'(229);
            5'd19:   v = Z_W'(115);
            5'd20:   v = Z_W'(57);
            5'd21:   v = Z_W'(29);
            5'd22:   v = Z_W'(14);
            5'd23:   v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/jca_prep.sv =====
// Input stage: segment differences, quadrant folding and scaling into CORDIC form.
module jca_prep #(
    parameter int COORD_BITS = jca_pkg::COORD_BITS_DEF,
    parameter int XY_W       = jca_pkg::COORD_BITS_DEF + jca_pkg::PRE_SHIFT + 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [8*COORD_BITS-1:0]      s_tdata,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [XY_W-1:0]       out_x1,
    output logic signed [XY_W-1:0]       out_y1,
    output logic signed [XY_W-1:0]       out_x2,
    output logic signed [XY_W-1:0]       out_y2,
    output jca_pkg::side_t               out_side
);
    import jca_pkg::*;

    localparam int C = COORD_BITS;

    logic [C-1:0] bx, by, ex, ey, lx, ly, fx, fy;
    logic signed [C:0] dx1, dy1, dx2, dy2, yv1, yv2;
    logic [C:0] ax1, ax2;
    side_t side_next;
    logic signed [XY_W-1:0] x1_next, y1_next, x2_next, y2_next;
    logic valid_reg;
    logic signed [XY_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    side_t side_reg;

    assign bx = s_tdata[0*C +: C];
    assign by = s_tdata[1*C +: C];
    assign ex = s_tdata[2*C +: C];
    assign ey = s_tdata[3*C +: C];
    assign lx = s_tdata[4*C +: C];
    assign ly = s_tdata[5*C +: C];
    assign fx = s_tdata[6*C +: C];
    assign fy = s_tdata[7*C +: C];

    always_comb begin
        dx1 = signed'({1'b0, ex}) - signed'({1'b0, bx});
        dy1 = signed'({1'b0, ey}) - signed'({1'b0, by});
        dx2 = signed'({1'b0, fx}) - signed'({1'b0, lx});
        dy2 = signed'({1'b0, fy}) - signed'({1'b0, ly});
        // Fold into the right half plane: vector (|dx|, dy * sign(dx)).
        ax1 = dx1[C] ? -dx1 : dx1;
        ax2 = dx2[C] ? -dx2 : dx2;
        yv1 = dx1[C] ? -dy1 : dy1;
        yv2 = dx2[C] ? -dy2 : dy2;
        x1_next = signed'(XY_W'(ax1)) <<< PRE_SHIFT;
        x2_next = signed'(XY_W'(ax2)) <<< PRE_SHIFT;
        y1_next = XY_W'(yv1) <<< PRE_SHIFT;
        y2_next = XY_W'(yv2) <<< PRE_SHIFT;
        if (dx1 == '0) begin
            side_next.kind1 = KIND_EQ;
        end else if (dx1[C]) begin
            side_next.kind1 = KIND_NEG;
        end else begin
            side_next.kind1 = KIND_POS;
        end
        if (dx2 == '0) begin
            side_next.kind2 = KIND_EQ;
        end else if (dx2[C]) begin
            side_next.kind2 = KIND_NEG;
        end else begin
            side_next.kind2 = KIND_POS;
        end
    end

    assign s_tready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x1_reg   <= x1_next;
            y1_reg   <= y1_next;
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x1    = x1_reg;
    assign out_y1    = y1_reg;
    assign out_x2    = x2_reg;
    assign out_y2    = y2_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/jca_cell.sv =====
// One CORDIC vectoring iteration for both segments, with its own pipeline register.
module jca_cell #(
    parameter int XY_W = jca_pkg::COORD_BITS_DEF + jca_pkg::PRE_SHIFT + 3,
    parameter int STEP = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [XY_W-1:0]        in_x1,
    input  logic signed [XY_W-1:0]        in_y1,
    input  logic signed [jca_pkg::Z_W-1:0] in_z1,
    input  logic signed [XY_W-1:0]        in_x2,
    input  logic signed [XY_W-1:0]        in_y2,
    input  logic signed [jca_pkg::Z_W-1:0] in_z2,
    input  jca_pkg::side_t                in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [XY_W-1:0]        out_x1,
    output logic signed [XY_W-1:0]        out_y1,
    output logic signed [jca_pkg::Z_W-1:0] out_z1,
    output logic signed [XY_W-1:0]        out_x2,
    output logic signed [XY_W-1:0]        out_y2,
    output logic signed [jca_pkg::Z_W-1:0] out_z2,
    output jca_pkg::side_t                out_side
);
    import jca_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = atan_deg(5'(STEP));

    logic signed [XY_W-1:0] x1_next, y1_next, x2_next, y2_next;
    logic signed [Z_W-1:0]  z1_next, z2_next;
    logic valid_reg;
    logic signed [XY_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [Z_W-1:0]  z1_reg, z2_reg;
    side_t side_reg;

    // Rotate toward the x axis; the shifts floor like the arithmetic model.
    always_comb begin
        if (in_y1 > 0) begin
            x1_next = in_x1 + (in_y1 >>> STEP);
            y1_next = in_y1 - (in_x1 >>> STEP);
            z1_next = in_z1 + ANGLE;
        end else begin
            x1_next = in_x1 - (in_y1 >>> STEP);
            y1_next = in_y1 + (in_x1 >>> STEP);
            z1_next = in_z1 - ANGLE;
        end
        if (in_y2 > 0) begin
            x2_next = in_x2 + (in_y2 >>> STEP);
            y2_next = in_y2 - (in_x2 >>> STEP);
            z2_next = in_z2 + ANGLE;
        end else begin
            x2_next = in_x2 - (in_y2 >>> STEP);
            y2_next = in_y2 + (in_x2 >>> STEP);
            z2_next = in_z2 - ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            x1_reg   <= x1_next;
            y1_reg   <= y1_next;
            z1_reg   <= z1_next;
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            z2_reg   <= z2_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x1    = x1_reg;
    assign out_y1    = y1_reg;
    assign out_z1    = z1_reg;
    assign out_x2    = x2_reg;
    assign out_y2    = y2_reg;
    assign out_z2    = z2_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/jca_post.sv =====
// Output stage: rounding, quadrant offsets, theta2 relative to theta1, saturation.
module jca_post #(
    parameter int ANGLE_FRAC_BITS = jca_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [jca_pkg::Z_W-1:0] in_z1,
    input  logic signed [jca_pkg::Z_W-1:0] in_z2,
    input  jca_pkg::side_t                 in_side,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [jca_pkg::OUT_DATA_W-1:0] m_tdata
);
    import jca_pkg::*;

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0]   HALF   = Z_W'(1) <<< (SH - 1);
    localparam logic signed [ANG_W-1:0] ONE80  = ANG_W'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [ANG_W-1:0] NINETY = ANG_W'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [ANG_W-1:0] SAT_MAX = ANG_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [ANG_W-1:0] SAT_MIN = -ANG_W'(2 ** (OUT_W - 1));

    logic signed [Z_W-1:0]   r1, r2;
    logic signed [ANG_W-1:0] a1, a2, t1, t2;
    logic signed [OUT_W-1:0] first_next, second_next;
    logic valid_reg;
    logic signed [OUT_W-1:0] first_reg, second_reg;

    always_comb begin
        r1 = (in_z1 + HALF) >>> SH;
        r2 = (in_z2 + HALF) >>> SH;
        a1 = ANG_W'(r1);
        a2 = ANG_W'(r2);
        case (in_side.kind1)
            KIND_NEG: t1 = a1;
            KIND_POS: t1 = ONE80 + a1;
            default:  t1 = NINETY;
        endcase
        // An equal-x second segment reports 90 without subtracting theta1.
        case (in_side.kind2)
            KIND_NEG: t2 = a2 - t1;
            KIND_POS: t2 = ONE80 + a2 - t1;
            default:  t2 = NINETY;
        endcase
        if (t1 > SAT_MAX) begin
            first_next = OUT_W'(SAT_MAX);
        end else if (t1 < SAT_MIN) begin
            first_next = OUT_W'(SAT_MIN);
        end else begin
            first_next = OUT_W'(t1);
        end
        if (t2 > SAT_MAX) begin
            second_next = OUT_W'(SAT_MAX);
        end else if (t2 < SAT_MIN) begin
            second_next = OUT_W'(SAT_MIN);
        end else begin
            second_next = OUT_W'(t2);
        end
    end

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2 * OUT_W){1'b0}}, second_reg, first_reg};

endmodule

// ===== hw/rtl/two_link_joint_angles.sv =====
// Top level of the two-link joint angle pipeline.
// Takes the pixel positions of four markers (base, elbow, second link, end effector) and
// returns theta1 and theta2 in degrees as signed fixed point with ANGLE_FRAC_BITS fraction
// bits. Both atan terms come from a chain of CORDIC_STEPS vectoring cells, one iteration per
// cell, with an input stage in front and a rounding and saturation stage behind. Each stage is
// registered, and the block takes one input transfer per cycle unless backpressure stalls it;
// every stage has its own valid bit and holds its data only while the stage after it is full
// and stalled, so bubbles close up under backpressure.
module two_link_joint_angles #(
    parameter int COORD_BITS      = jca_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = jca_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = jca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // base_x, base_y, elbow_x, elbow_y, link_x, link_y, effector_x, effector_y
    input  logic [8*COORD_BITS-1:0]        s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // first_angle [17:0], second_angle [35:18], zero fill [39:36]
    output logic [jca_pkg::OUT_DATA_W-1:0] m_tdata
);
    import jca_pkg::*;

    localparam int XY_W = COORD_BITS + PRE_SHIFT + 3;
    localparam int N    = CORDIC_STEPS;

    logic                   vld [0:N];
    logic                   rdy [0:N];
    logic signed [XY_W-1:0] x1  [0:N];
    logic signed [XY_W-1:0] y1  [0:N];
    logic signed [Z_W-1:0]  z1  [0:N];
    logic signed [XY_W-1:0] x2  [0:N];
    logic signed [XY_W-1:0] y2  [0:N];
    logic signed [Z_W-1:0]  z2  [0:N];
    side_t                  sd  [0:N];

    jca_prep #(
        .COORD_BITS (COORD_BITS),
        .XY_W       (XY_W)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_x1    (x1[0]),
        .out_y1    (y1[0]),
        .out_x2    (x2[0]),
        .out_y2    (y2[0]),
        .out_side  (sd[0])
    );

    assign z1[0] = '0;
    assign z2[0] = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        jca_cell #(
            .XY_W (XY_W),
            .STEP (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_x1     (x1[k]),
            .in_y1     (y1[k]),
            .in_z1     (z1[k]),
            .in_x2     (x2[k]),
            .in_y2     (y2[k]),
            .in_z2     (z2[k]),
            .in_side   (sd[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_x1    (x1[k+1]),
            .out_y1    (y1[k+1]),
            .out_z1    (z1[k+1]),
            .out_x2    (x2[k+1]),
            .out_y2    (y2[k+1]),
            .out_z2    (z2[k+1]),
            .out_side  (sd[k+1])
        );
    end

    jca_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld[N]),
        .in_ready (rdy[N]),
        .in_z1    (z1[N]),
        .in_z2    (z2[N]),
        .in_side  (sd[N]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sim/two_link_joint_angles_tb.sv =====
// Self-checking testbench for the two-link joint angle pipeline with a built-in CORDIC predictor.
module two_link_joint_angles_tb;

    localparam int STEPS       = jca_pkg::CORDIC_STEPS_DEF;
    localparam int FRAC        = jca_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int Z_FRAC      = 20;
    localparam int SCALE_SHIFT = 24;
    localparam longint HALF_TURN   = longint'(180) <<< FRAC;
    localparam longint RIGHT_ANGLE = longint'(90) <<< FRAC;
    localparam longint ANGLE_MAX   = 131071;
    localparam longint ANGLE_MIN   = -131072;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_PRINTS  = 40;

    // Packed to match s_tdata: base_x in the lowest bits, effector_y in the highest.
    typedef struct packed {
        logic [11:0] effector_y;
        logic [11:0] effector_x;
        logic [11:0] link_y;
        logic [11:0] link_x;
        logic [11:0] elbow_y;
        logic [11:0] elbow_x;
        logic [11:0] base_y;
        logic [11:0] base_x;
    } markers_t;

    typedef struct packed {
        logic [3:0]         fill;
        logic signed [17:0] second_angle;
        logic signed [17:0] first_angle;
    } angles_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // base_x, base_y, elbow_x, elbow_y, link_x, link_y, effector_x, effector_y
    logic [95:0]                    s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // first_angle, second_angle, zero fill
    logic [jca_pkg::OUT_DATA_W-1:0] m_tdata;

    markers_t marker_pending_q[$];
    angles_t  angle_expect_q[$];

    int send_idle_pct   = 10;
    int recv_idle_pct   = 48;
    int error_count     = 0;
    int sets_sent       = 0;
    int pairs_checked   = 0;
    int idle_cycles     = 0;
    int hold_left       = 0;
    int holds_done      = 0;
    int kind1_count[3]  = '{0, 0, 0};
    int kind2_count[3]  = '{0, 0, 0};

    // atan(2^-i) in degrees with 20 fraction bits.
    longint atan_step_deg[24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    two_link_joint_angles u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic jca_pkg::seg_kind_t segment_kind(longint dx);
        if (dx == 0) begin
            return jca_pkg::KIND_EQ;
        end else if (dx < 0) begin
            return jca_pkg::KIND_NEG;
        end
        return jca_pkg::KIND_POS;
    endfunction

    // Vectoring CORDIC on (|dx|, dy*sign(dx)); returns atan(dy/dx) in output fraction bits.
    function automatic longint vector_atan_deg(longint dy, longint dx);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     i;
        x = (dx < 0) ? -dx : dx;
        y = (dx < 0) ? -dy : dy;
        x = x <<< SCALE_SHIFT;
        y = y <<< SCALE_SHIFT;
        z = 0;
        for (i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step_deg[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step_deg[i];
            end
        end
        return (z + (longint'(1) <<< (Z_FRAC - FRAC - 1))) >>> (Z_FRAC - FRAC);
    endfunction

    function automatic logic signed [17:0] clamp_angle(longint v);
        if (v > ANGLE_MAX) v = ANGLE_MAX;
        if (v < ANGLE_MIN) v = ANGLE_MIN;
        return v[17:0];
    endfunction

    function automatic angles_t predict_angles(markers_t m);
        longint  dx1;
        longint  dy1;
        longint  dx2;
        longint  dy2;
        longint  t1;
        longint  t2;
        angles_t r;
        dx1 = longint'(m.elbow_x) - longint'(m.base_x);
        dy1 = longint'(m.elbow_y) - longint'(m.base_y);
        dx2 = longint'(m.effector_x) - longint'(m.link_x);
        dy2 = longint'(m.effector_y) - longint'(m.link_y);
        case (segment_kind(dx1))
            jca_pkg::KIND_EQ:  t1 = RIGHT_ANGLE;
            jca_pkg::KIND_NEG: t1 = vector_atan_deg(dy1, dx1);
            default:           t1 = HALF_TURN + vector_atan_deg(dy1, dx1);
        endcase
        // A vertical second segment reports a plain right angle, not relative to theta1.
        case (segment_kind(dx2))
            jca_pkg::KIND_EQ:  t2 = RIGHT_ANGLE;
            jca_pkg::KIND_NEG: t2 = vector_atan_deg(dy2, dx2) - t1;
            default:           t2 = HALF_TURN + vector_atan_deg(dy2, dx2) - t1;
        endcase
        r.fill         = '0;
        r.first_angle  = clamp_angle(t1);
        r.second_angle = clamp_angle(t2);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < MAX_PRINTS) begin
            $display("mismatch after %0d pairs: %s got %0d expected %0d",
                     pairs_checked, what, got, want);
        end
        error_count++;
    endtask

    function automatic logic [11:0] clamp_coord(int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return v[11:0];
    endfunction

    function automatic logic [11:0] edge_coord();
        return $urandom_range(1) ? 12'hFFF : 12'h000;
    endfunction

    function automatic markers_t random_markers();
        markers_t m;
        m = {$urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0: m.elbow_x = m.base_x;
            1: m.effector_x = m.link_x;
            2: begin
                m.elbow_x    = clamp_coord(int'(m.base_x) + int'($urandom_range(16)) - 8);
                m.elbow_y    = clamp_coord(int'(m.base_y) + int'($urandom_range(16)) - 8);
                m.effector_x = clamp_coord(int'(m.link_x) + int'($urandom_range(16)) - 8);
                m.effector_y = clamp_coord(int'(m.link_y) + int'($urandom_range(16)) - 8);
            end
            3: begin
                m.base_x     = edge_coord();
                m.base_y     = edge_coord();
                m.elbow_x    = edge_coord();
                m.elbow_y    = edge_coord();
                m.link_x     = edge_coord();
                m.link_y     = edge_coord();
                m.effector_x = edge_coord();
                m.effector_y = edge_coord();
            end
            4: begin
                m.elbow_y    = m.base_y;
                m.effector_y = m.link_y;
            end
            5: begin
                m.elbow_x = m.base_x;
                m.effector_x = m.link_x;
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic queue_markers(int bx, int by, int ex, int ey,
                                 int lx, int ly, int fx, int fy);
        markers_t m;
        m.base_x     = 12'(bx);
        m.base_y     = 12'(by);
        m.elbow_x    = 12'(ex);
        m.elbow_y    = 12'(ey);
        m.link_x     = 12'(lx);
        m.link_y     = 12'(ly);
        m.effector_x = 12'(fx);
        m.effector_y = 12'(fy);
        marker_pending_q.push_back(m);
    endtask

    task automatic queue_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            marker_pending_q.push_back(random_markers());
        end
    endtask

    // Holds the sender back until every outstanding angle pair has come out.
    task automatic wait_drained();
        while (marker_pending_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (angle_expect_q.size() != 0) @(negedge aclk);
    endtask

    // Sender: offers queued marker sets and predicts each one at its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                angle_expect_q.push_back(predict_angles(markers_t'(s_tdata)));
                kind1_count[int'(segment_kind(longint'(s_tdata[35:24])
                                              - longint'(s_tdata[11:0])))]++;
                kind2_count[int'(segment_kind(longint'(s_tdata[83:72])
                                              - longint'(s_tdata[59:48])))]++;
                sets_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (marker_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= marker_pending_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer and throttles m_tready, with two long holds.
    always @(posedge aclk) begin
        angles_t got;
        angles_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (angle_expect_q.size() == 0) begin
                    report_mismatch("unexpected result, first_angle",
                                    longint'(got.first_angle), longint'(0));
                end else begin
                    want = angle_expect_q.pop_front();
                    if (got.first_angle !== want.first_angle) begin
                        report_mismatch("first_angle", longint'(got.first_angle),
                                        longint'(want.first_angle));
                    end
                    if (got.second_angle !== want.second_angle) begin
                        report_mismatch("second_angle", longint'(got.second_angle),
                                        longint'(want.second_angle));
                    end
                end
                pairs_checked++;
            end
            if ((holds_done == 0 && pairs_checked >= 150) ||
                (holds_done == 1 && pairs_checked >= 600)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sets: vertical segments, horizontal segments, steep and shallow slopes,
        // corner coordinates and alternating bit patterns.
        queue_markers(0, 0, 0, 0, 0, 0, 0, 0);
        queue_markers(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        queue_markers(4095, 0, 0, 4095, 0, 4095, 4095, 0);
        queue_markers(0, 4095, 4095, 0, 4095, 0, 0, 4095);
        queue_markers(2000, 500, 1000, 500, 1000, 7, 3000, 7);
        queue_markers(1, 0, 0, 4095, 4095, 4095, 4094, 0);
        queue_markers(0, 4095, 1, 0, 0, 0, 1, 4095);
        queue_markers(100, 100, 50, 150, 3000, 0, 3000, 4095);
        queue_markers(777, 0, 777, 4095, 10, 30, 20, 40);
        queue_markers(2000, 2000, 1000, 1000, 1000, 1000, 2000, 2000);
        queue_markers(4095, 0, 0, 4095, 4095, 4095, 0, 0);
        queue_markers('hAAA, 'h555, 'h555, 'hAAA, 'hAAA, 'h555, 'h555, 'hAAA);
        queue_markers('h555, 'hAAA, 'hAAA, 'h555, 'h555, 'hAAA, 'hAAA, 'h555);
        queue_markers(0, 0, 4095, 0, 4095, 4095, 0, 4095);
        queue_markers(4095, 4095, 4094, 4095, 0, 0, 1, 0);
        queue_markers(3000, 1000, 3001, 1001, 500, 2500, 499, 2499);
        queue_random(280);
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 10;
        queue_random(280);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(290);
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("Sent %0d marker sets and checked %0d angle pairs under three stall mixes",
                 sets_sent, pairs_checked);
        $display("theta1 vertical/left/right %0d/%0d/%0d, theta2 %0d/%0d/%0d, %0d long holds",
                 kind1_count[0], kind1_count[1], kind1_count[2],
                 kind2_count[0], kind2_count[1], kind2_count[2], holds_done);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
